[hdl/stbs_pkg.sv]
`default_nettype none
package stbs_pkg;

  localparam int MAX_ENTRIES  = 1024;
  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CFG_W        = 11;
  localparam int SLOT_W       = 10;
  localparam int FIELD_W      = 64;
  localparam int KEY_BYTES    = 8;
  localparam int OFFSET_BYTES = 8;
  localparam int KEY_W        = 8 * KEY_BYTES;
  localparam int OFF_W        = 8 * OFFSET_BYTES;
  localparam int IN_DATA_W    = ((SLOT_W + 2 * FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = FIELD_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_PUT    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // classified item as it travels from front to back
  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   slot;
    logic [KEY_W-1:0]   key;
    logic [OFF_W-1:0]   offset;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/stbs_front.sv]
`default_nettype none
module stbs_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_kind,
  input  wire logic [stbs_pkg::SLOT_W-1:0]     in_slot,
  input  wire logic [stbs_pkg::FIELD_W-1:0]    in_key,
  input  wire logic [stbs_pkg::FIELD_W-1:0]    in_offset,
  output logic                                 cmd_valid,
  output stbs_pkg::cmd_t                       cmd,
  input  wire logic                            cmd_pop
);

  stbs_pkg::cmd_t                     q_mem [stbs_pkg::QUEUE_DEPTH];
  logic [stbs_pkg::QPTR_W-1:0]        wr_ptr;
  logic [stbs_pkg::QPTR_W-1:0]        rd_ptr;
  logic [stbs_pkg::QCNT_W-1:0]        count;
  logic                               accept;
  logic                               push;
  logic                               pop;
  logic                               slot_ok;
  stbs_pkg::cmd_t                     cmd_in;

  assign in_ready  = (count != stbs_pkg::QCNT_W'(stbs_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;
  // a put beyond the table is dropped here
  assign slot_ok   = (32'(in_slot) < 32'(stbs_pkg::MAX_ENTRIES));
  assign push      = accept && (in_kind == stbs_pkg::KIND_LOOKUP || slot_ok);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (count != '0);
  assign cmd       = q_mem[rd_ptr];

  always_comb begin
    cmd_in.kind   = stbs_pkg::kind_t'(in_kind);
    cmd_in.slot   = stbs_pkg::IDX_W'(in_slot);
    cmd_in.key    = in_key[stbs_pkg::KEY_W-1:0];
    cmd_in.offset = in_offset[stbs_pkg::OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == stbs_pkg::QPTR_W'(stbs_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == stbs_pkg::QPTR_W'(stbs_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/stbs_back.sv]
`default_nettype none
module stbs_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [stbs_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                            cmd_valid,
  input  wire stbs_pkg::cmd_t                  cmd,
  output logic                                 cmd_pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_found,
  output logic [stbs_pkg::FIELD_W-1:0]         out_offset
);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t                         state;
  logic [stbs_pkg::CFG_W-1:0]     entries_in_use;
  logic [stbs_pkg::KEY_W-1:0]     key_mem [stbs_pkg::MAX_ENTRIES];
  logic [stbs_pkg::OFF_W-1:0]     off_mem [stbs_pkg::MAX_ENTRIES];
  logic [stbs_pkg::KEY_W-1:0]     rd_key;
  logic [stbs_pkg::OFF_W-1:0]     rd_off;
  logic [stbs_pkg::IDX_W-1:0]     rd_addr;
  logic [stbs_pkg::KEY_W-1:0]     key;
  logic [stbs_pkg::CNT_W-1:0]     lo;
  logic [stbs_pkg::CNT_W-1:0]     hi;
  logic [stbs_pkg::IDX_W-1:0]     cur_mid;
  logic [stbs_pkg::CNT_W-1:0]     lo_next;
  logic [stbs_pkg::CNT_W-1:0]     hi_next;
  logic [stbs_pkg::CNT_W-1:0]     lim;
  logic [stbs_pkg::CNT_W-1:0]     span;
  logic                           out_free;
  logic                           out_load;
  logic                           key_eq;
  logic                           key_lt;
  logic                           finish;
  logic                           do_put;

  assign out_free = !out_valid || out_ready;
  assign lim = (32'(entries_in_use) > 32'(stbs_pkg::MAX_ENTRIES))
               ? stbs_pkg::CNT_W'(stbs_pkg::MAX_ENTRIES)
               : stbs_pkg::CNT_W'(entries_in_use);
  assign key_eq = (key == rd_key);
  assign key_lt = (key < rd_key);
  assign finish = key_eq || (lo_next >= hi_next);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (key_lt) begin
      hi_next = {1'b0, cur_mid};
    end else if (!key_eq) begin
      lo_next = {1'b0, cur_mid} + 1'b1;
    end
  end

  // pick the next probe, the queue pop, the table write and the output load; the read data lands in the next cycle
  always_comb begin
    cmd_pop  = 1'b0;
    do_put   = 1'b0;
    out_load = 1'b0;
    span     = '0;
    rd_addr  = cur_mid;
    case (state)
      S_IDLE: begin
        cmd_pop  = cmd_valid && (cmd.kind == stbs_pkg::KIND_PUT || lim != '0 || out_free);
        do_put   = cmd_pop && (cmd.kind == stbs_pkg::KIND_PUT);
        out_load = cmd_pop && (cmd.kind == stbs_pkg::KIND_LOOKUP) && (lim == '0);
        span     = lim - 1'b1;
        rd_addr  = stbs_pkg::IDX_W'(span >> 1);
      end
      S_SEARCH: begin
        out_load = finish && out_free;
        if (!finish) begin
          span    = hi_next - lo_next - 1'b1;
          rd_addr = stbs_pkg::IDX_W'(lo_next + (span >> 1));
        end
      end
      default: begin
        rd_addr = cur_mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_put) begin
      key_mem[cmd.slot] <= cmd.key;
      off_mem[cmd.slot] <= cmd.offset;
    end
    rd_key <= key_mem[rd_addr];
    rd_off <= off_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop && cmd.kind == stbs_pkg::KIND_LOOKUP) begin
            if (lim == '0) begin
              out_found  <= 1'b0;
              out_offset <= '0;
            end else begin
              lo      <= '0;
              hi      <= lim;
              cur_mid <= rd_addr;
              key     <= cmd.key;
              state   <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (finish) begin
            // hold the probe until the output register is free
            if (out_free) begin
              out_found  <= key_eq;
              out_offset <= key_eq ? stbs_pkg::FIELD_W'(rd_off) : '0;
              state      <= S_IDLE;
            end
          end else begin
            lo      <= lo_next;
            hi      <= hi_next;
            cur_mid <= rd_addr;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_range_open: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> lo < hi)
    else $error("search range empty while searching");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> ({1'b0, cur_mid} >= lo && {1'b0, cur_mid} < hi))
    else $error("probe outside search range");

  a_hi_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> hi <= stbs_pkg::CNT_W'(stbs_pkg::MAX_ENTRIES))
    else $error("upper bound beyond table");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_offset == '0)
    else $error("miss with non-zero offset");

  a_no_put_in_search: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> !do_put)
    else $error("table written during a search");

endmodule
`default_nettype wire

[hdl/sorted_table_binary_search_unit.sv]
// Lookup: the result follows a search of n probes, n being at most
// floor(log2(min(entries_in_use, 1024))) + 1 (11 for 1024); a lookup on an empty table
// answers with a miss without a search. Put items give no result.
// Throughput: puts one per cycle while the back end is idle; lookups one search at a time,
// and a two-item queue accepts input while a search runs or a result waits, until it is full.
// rst (synchronous) clears queue, search state, output valid and entries_in_use; table undefined.
`default_nettype none
module sorted_table_binary_search_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [stbs_pkg::CFG_W-1:0]         cfg_wdata,   // entries_in_use
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [stbs_pkg::IN_DATA_W-1:0]     s_axis_tdata, // slot_index, search_key, offset_value
  input  wire logic                               s_axis_tuser, // kind
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [stbs_pkg::OUT_DATA_W-1:0]         m_axis_tdata, // found_offset
  output logic                                    m_axis_tuser  // found
);

  localparam int KEY_LO = stbs_pkg::SLOT_W;
  localparam int OFF_LO = stbs_pkg::SLOT_W + stbs_pkg::FIELD_W;

  logic            cmd_valid;
  logic            cmd_pop;
  stbs_pkg::cmd_t  cmd;

  stbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_slot   (s_axis_tdata[stbs_pkg::SLOT_W-1:0]),
    .in_key    (s_axis_tdata[KEY_LO +: stbs_pkg::FIELD_W]),
    .in_offset (s_axis_tdata[OFF_LO +: stbs_pkg::FIELD_W]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  stbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_found  (m_axis_tuser),
    .out_offset (m_axis_tdata)
  );

endmodule
`default_nettype wire
